### rtl/rgb_to_hsv_converter_macros.svh
// Assertion macros shared by the RGB to HSV converter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define RTV_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define RTV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

### rtl/rtv_pkg.sv
// Types and constants for the RGB to HSV converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rtv_pkg;

    localparam int ChanBits = 8;
    localparam int HueBits  = 16;
    localparam int SatBits  = 8;
    // 6 * 255 = 1530 fits in 11 bits
    localparam int NumBits  = 11;

    // One input pixel
    typedef struct packed {
        logic [ChanBits-1:0] red;
        logic [ChanBits-1:0] green;
        logic [ChanBits-1:0] blue;
    } pixel_t;

    // One converted result
    typedef struct packed {
        logic [HueBits-1:0]  hue;
        logic [SatBits-1:0]  saturation;
        logic [ChanBits-1:0] value;
    } hsv_t;

    // Classified pixel handed from the front end to the divider pipeline
    typedef struct packed {
        logic                  gray;
        logic [NumBits-1:0]    hue_num;   // hue numerator, below hue_div
        logic [NumBits-1:0]    hue_div;   // 6 * (max - min)
        logic [2*ChanBits-1:0] sat_num;   // (max - min) * 255
        logic [ChanBits-1:0]   sat_div;   // max, also the value channel
    } task_t;

endpackage

### rtl/rtv_front.sv
// Front end: takes requests, finds max/min and sector, forms the divider operands.
// Depends on rtv_pkg.
`timescale 1ns / 1ps

module rtv_front
    import rtv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  pixel_t pixel,
    output logic   busy,
    input  logic   queue_full,
    output logic   push,
    output task_t  push_task
);

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    logic                f_valid_reg;
    task_t               f_task_reg;
    task_t               f_task_next;
    sector_t             sector;
    logic [ChanBits-1:0] mx;
    logic [ChanBits-1:0] mn;
    logic [ChanBits-1:0] d;
    logic [NumBits-1:0]  six_d;
    logic [NumBits:0]    num_wide;
    logic                load;

    // Channel extremes and largest-channel sector (red, then green, then blue on ties)
    always_comb
    begin
        if (pixel.red >= pixel.green && pixel.red >= pixel.blue)
        begin
            sector = SEC_RED;
            mx     = pixel.red;
        end
        else if (pixel.green >= pixel.blue)
        begin
            sector = SEC_GREEN;
            mx     = pixel.green;
        end
        else
        begin
            sector = SEC_BLUE;
            mx     = pixel.blue;
        end

        mn = pixel.red;
        if (pixel.green < mn)
            mn = pixel.green;
        if (pixel.blue < mn)
            mn = pixel.blue;

        d     = mx - mn;
        six_d = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
    end

    // Hue numerator, always in [0, 6d); arithmetic is modulo 2^12
    always_comb
    begin
        case (sector)
            SEC_RED:
            begin
                num_wide = {4'b0, pixel.green} - {4'b0, pixel.blue};
                if (pixel.green < pixel.blue)
                    num_wide = num_wide + {1'b0, six_d};
            end
            SEC_GREEN:
                num_wide = {3'b0, d, 1'b0} + {4'b0, pixel.blue} - {4'b0, pixel.red};
            SEC_BLUE:
                num_wide = {2'b0, d, 2'b0} + {4'b0, pixel.red} - {4'b0, pixel.green};
            default:
                num_wide = '0;
        endcase
    end

    always_comb
    begin
        f_task_next.gray    = (d == '0);
        f_task_next.hue_num = num_wide[NumBits-1:0];
        f_task_next.hue_div = six_d;
        f_task_next.sat_num = {d, 8'b0} - {8'b0, d};
        f_task_next.sat_div = mx;
    end

    // Hand-off to the queue; hold while it is full
    assign push      = f_valid_reg && !queue_full;
    assign busy      = f_valid_reg && queue_full;
    assign push_task = f_task_reg;
    assign load      = !f_valid_reg || push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (load)
            f_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (load && start)
            f_task_reg <= f_task_next;
    end

endmodule

### rtl/rtv_queue.sv
// Short FIFO between the front end and the divider pipeline.
// Depends on rtv_pkg.
`timescale 1ns / 1ps

module rtv_queue
    import rtv_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  task_t push_task,
    output logic  full,
    output logic  pop,
    output task_t pop_task
);

    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntBits = $clog2(DEPTH + 1);

    task_t              mem_reg [DEPTH];
    logic [PtrBits-1:0] wr_ptr_reg;
    logic [PtrBits-1:0] rd_ptr_reg;
    logic [CntBits-1:0] count_reg;
    logic [CntBits-1:0] count_next;

    // The pipeline behind never stalls, so any held entry leaves at once
    assign pop      = (count_reg != '0);
    assign full     = (count_reg == CntBits'(DEPTH));
    assign pop_task = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_task;
    end

endmodule

### rtl/rtv_back.sv
// Back end: radix-2 restoring divider pipeline for hue and saturation, one bit a stage.
// Depends on rtv_pkg.
`timescale 1ns / 1ps

module rtv_back
    import rtv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  task_t in_task,
    output logic  done,
    output hsv_t  hsv
);

    localparam int HueSteps = HueBits;
    localparam int SatSteps = SatBits;

    typedef struct packed {
        logic                gray;
        logic [NumBits-1:0]  hrem;
        logic [NumBits-1:0]  hdiv;
        logic [HueBits-1:0]  hq;
        logic [ChanBits-1:0] srem;
        logic [ChanBits-1:0] snum_lo;
        logic [ChanBits-1:0] sdiv;
        logic [SatBits-1:0]  sq;
    } stage_t;

    stage_t              stage_reg  [HueSteps];
    stage_t              stage_next [HueSteps];
    stage_t              stage_init;
    logic [HueSteps-1:0] valid_reg;
    logic                done_reg;
    hsv_t                hsv_reg;

    // One quotient bit of hue, and of saturation while sat_step is set
    function automatic stage_t div_step(input stage_t s, input logic sat_step);
        stage_t          r;
        logic [NumBits:0]  th;
        logic [NumBits:0]  dh;
        logic [ChanBits:0] ts;
        logic [ChanBits:0] ds;
        r  = s;
        th = {s.hrem, 1'b0};
        dh = th - {1'b0, s.hdiv};
        if (th >= {1'b0, s.hdiv})
        begin
            r.hrem = dh[NumBits-1:0];
            r.hq   = {s.hq[HueBits-2:0], 1'b1};
        end
        else
        begin
            r.hrem = th[NumBits-1:0];
            r.hq   = {s.hq[HueBits-2:0], 1'b0};
        end
        if (sat_step)
        begin
            ts        = {s.srem, s.snum_lo[ChanBits-1]};
            ds        = ts - {1'b0, s.sdiv};
            r.snum_lo = {s.snum_lo[ChanBits-2:0], 1'b0};
            if (ts >= {1'b0, s.sdiv})
            begin
                r.srem = ds[ChanBits-1:0];
                r.sq   = {s.sq[SatBits-2:0], 1'b1};
            end
            else
            begin
                r.srem = ts[ChanBits-1:0];
                r.sq   = {s.sq[SatBits-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // Load the operands into the first stage
    always_comb
    begin
        stage_init.gray    = in_task.gray;
        stage_init.hrem    = in_task.hue_num;
        stage_init.hdiv    = in_task.hue_div;
        stage_init.hq      = '0;
        stage_init.srem    = in_task.sat_num[2*ChanBits-1:ChanBits];
        stage_init.snum_lo = in_task.sat_num[ChanBits-1:0];
        stage_init.sdiv    = in_task.sat_div;
        stage_init.sq      = '0;
    end

    always_comb
    begin
        stage_next[0] = div_step(stage_init, 1'b1);
        for (int k = 1; k < HueSteps; k++)
            stage_next[k] = div_step(stage_reg[k-1], k < SatSteps);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[HueSteps-2:0], in_valid};
            done_reg  <= valid_reg[HueSteps-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < HueSteps; k++)
            stage_reg[k] <= stage_next[k];
    end

    // Result register; gray pixels give zero hue and saturation
    always_ff @(posedge clk)
    begin
        if (valid_reg[HueSteps-1])
        begin
            hsv_reg.hue        <= stage_reg[HueSteps-1].gray ? '0 : stage_reg[HueSteps-1].hq;
            hsv_reg.saturation <= stage_reg[HueSteps-1].gray ? '0 : stage_reg[HueSteps-1].sq;
            hsv_reg.value      <= stage_reg[HueSteps-1].sdiv;
        end
    end

    assign done = done_reg;
    assign hsv  = hsv_reg;

endmodule

### rtl/rgb_to_hsv_converter.sv
// Path: a request passes the front register, a queue slot, 16 divider stages and the result
// register; done rises in the same cycle as the result register loads.
// Throughput: one pixel per cycle; every stage moves one request each cycle.
// busy rises only if the front register and queue both fill, which the pipeline prevents for QUEUE_DEPTH >= 2.
// Reset (rst_n, asynchronous, active low) clears all valid bits and queue pointers.
// Top level: instantiates rtv_front, rtv_queue and rtv_back; depends on rtv_pkg.
`timescale 1ns / 1ps
`include "rgb_to_hsv_converter_macros.svh"

module rgb_to_hsv_converter
    import rtv_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  pixel_t pixel,
    output logic   busy,
    output logic   done,
    output hsv_t   hsv
);

    logic  queue_full;
    logic  push;
    task_t push_task;
    logic  pop;
    task_t pop_task;

    // Classify and form divider operands
    rtv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .pixel      (pixel),
        .busy       (busy),
        .queue_full (queue_full),
        .push       (push),
        .push_task  (push_task)
    );

    // Decouple front end from divider pipeline
    rtv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_task (push_task),
        .full      (queue_full),
        .pop       (pop),
        .pop_task  (pop_task)
    );

    // Hue and saturation division
    rtv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pop),
        .in_task  (pop_task),
        .done     (done),
        .hsv      (hsv)
    );

    // Fixed latency from request to result
    `RTV_ASSERT_NEXT(latency_chk, start && !busy, ##18 done, "result strobe missing after request")
    // Queue never fills for QUEUE_DEPTH >= 2 since the pipeline drains one entry a cycle
    `RTV_ASSERT(no_busy_chk, 1'b1, !busy && !queue_full, "queue filled up unexpectedly")
    // Black pixel carries no hue and no saturation
    `RTV_ASSERT(black_chk, done && ~|hsv.value, ~|{hsv.hue, hsv.saturation}, "black pixel has colour")

endmodule
